/* src/i2c_ras_pkg.sv */
// types and codes shared by the i2c register access sequencer
`default_nettype none
package i2c_ras_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	localparam logic [2:0] CMD_NONE        = 3'd0;
	localparam logic [2:0] CMD_SEND_START  = 3'd1;
	localparam logic [2:0] CMD_SINGLE_RECV = 3'd2;
	localparam logic [2:0] CMD_RECV_START  = 3'd3;
	localparam logic [2:0] CMD_RECV_CONT   = 3'd4;
	localparam logic [2:0] CMD_RECV_FINISH = 3'd5;
	localparam logic [2:0] CMD_SEND_FINISH = 3'd6;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_RD_SWITCH = 7'b0000010,
		PH_RD_SINGLE = 7'b0000100,
		PH_RD_CONT   = 7'b0001000,
		PH_RD_FINISH = 7'b0010000,
		PH_WR_DATA   = 7'b0100000,
		PH_WR_FINISH = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       opcode;
		logic [6:0] slave_address;
		logic [7:0] register_address;
		logic       is_read;
		logic [7:0] write_byte;
		logic [7:0] byte_count;
		logic [7:0] event_rx_byte;
		logic       event_error;
	} req_t;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] target_address;
		logic       target_read;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic       done_res;
		logic       failed;
		logic       rejected;
	} res_t;

endpackage
`default_nettype wire

/* src/i2c_register_access_sequencer_unit.sv */
// I2C register access sequencer: each request (a start or a master core event) yields
// exactly one result carrying the next core command, a received byte with its index, or
// a completion or rejection status. A request is taken in the cycle it is offered whenever
// the input register is free or moving on, so one request per cycle is sustained while
// results are taken; its result passes from the input register into the result register,
// the two registers bracketing the sequencer state update.
`default_nettype none
module i2c_register_access_sequencer_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	output logic                     req_ready,
	input  wire i2c_ras_pkg::req_t   req,
	output logic                     res_valid,
	input  wire                      res_ready,
	output i2c_ras_pkg::res_t        res
);
	import i2c_ras_pkg::*;

	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	res_t res_s2;
	res_t step_res;
	logic adv;

	assign adv       = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || adv;

	i2c_ras_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule
`default_nettype wire

/* src/i2c_ras_fsm.sv */
// sequencer state and the per-request step logic
`default_nettype none
module i2c_ras_fsm (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      step,
	input  wire i2c_ras_pkg::req_t   item,
	output i2c_ras_pkg::res_t        result
);
	import i2c_ras_pkg::*;

	phase_t     phase_q, phase_d;
	logic [6:0] addr_q, addr_d;
	logic [7:0] total_q, total_d;
	logic [7:0] count_q, count_d;
	logic [7:0] wbyte_q, wbyte_d;
	logic       busy;
	res_t       res;

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		addr_d  = addr_q;
		total_d = total_q;
		count_d = count_q;
		wbyte_d = wbyte_q;
		case (phase_q)
			PH_RD_SWITCH, PH_RD_SINGLE, PH_RD_CONT, PH_RD_FINISH,
			PH_WR_DATA, PH_WR_FINISH: busy = 1'b1;
			default: busy = 1'b0;
		endcase
		if (item.opcode == OP_START) begin
			if (busy) begin
				res.rejected = 1'b1;
			end else begin
				addr_d  = item.slave_address;
				total_d = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
				count_d = 8'd0;
				wbyte_d = item.write_byte;
				phase_d = item.is_read ? PH_RD_SWITCH : PH_WR_DATA;
				res.command        = CMD_SEND_START;
				res.target_address = item.slave_address;
				res.tx_byte        = item.register_address;
			end
		end else if (!busy) begin
			phase_d = PH_IDLE;
		end else if (item.event_error) begin
			phase_d      = PH_IDLE;
			res.done_res = 1'b1;
			res.failed   = 1'b1;
		end else begin
			case (phase_q)
				PH_RD_SWITCH: begin
					res.target_address = addr_q;
					res.target_read    = 1'b1;
					if (total_q == 8'd1) begin
						phase_d     = PH_RD_SINGLE;
						res.command = CMD_SINGLE_RECV;
					end else begin
						phase_d     = PH_RD_CONT;
						res.command = CMD_RECV_START;
					end
				end
				PH_RD_SINGLE, PH_RD_FINISH: begin
					res.rx_valid = 1'b1;
					res.rx_byte  = item.event_rx_byte;
					res.rx_index = count_q;
					count_d      = count_q + 8'd1;
					phase_d      = PH_IDLE;
					res.done_res = 1'b1;
				end
				PH_RD_CONT: begin
					res.rx_valid       = 1'b1;
					res.rx_byte        = item.event_rx_byte;
					res.rx_index       = count_q;
					count_d            = count_q + 8'd1;
					res.target_address = addr_q;
					res.target_read    = 1'b1;
					if ({1'b0, count_q} + 9'd2 == {1'b0, total_q}) begin
						phase_d     = PH_RD_FINISH;
						res.command = CMD_RECV_FINISH;
					end else begin
						res.command = CMD_RECV_CONT;
					end
				end
				PH_WR_DATA: begin
					phase_d            = PH_WR_FINISH;
					res.command        = CMD_SEND_FINISH;
					res.target_address = addr_q;
					res.tx_byte        = wbyte_q;
				end
				PH_WR_FINISH: begin
					phase_d      = PH_IDLE;
					res.done_res = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			total_q <= '0;
			count_q <= '0;
			wbyte_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			total_q <= total_d;
			count_q <= count_d;
			wbyte_q <= wbyte_d;
		end
	end

	assign result = res;

`ifndef SYNTHESIS
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rejected |=> $stable(phase_q) && $stable(count_q))
		else $error("rejected request changed sequencer state");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == PH_IDLE)
		else $error("finished access did not return to idle");
	a_rx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rx_valid |-> phase_q == PH_RD_SINGLE || phase_q == PH_RD_CONT ||
			phase_q == PH_RD_FINISH)
		else $error("received byte outside a read phase");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.command == CMD_SEND_START |=> count_q == 8'd0 && total_q != 8'd0)
		else $error("start did not initialize read counters");
`endif

endmodule
`default_nettype wire
